FILE: rtl/scfla_pkg.sv
// ----------------------------------------------------------------------------
// scfla_pkg: shared types and constants for the size-class allocator
// Field widths of the request and response beats, status codes, commands and
// the controller state type.
// ----------------------------------------------------------------------------
package scfla_pkg;

	localparam int SIZE_W        = 16;	// size_bytes field
	localparam int ADDR_W        = 12;	// block_address / granted_address fields
	localparam int STATUS_W      = 2;
	localparam int GRANULE_SHIFT = 3;	// 8-byte granules
	localparam int GRANULE_BYTES = 8;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_OOM  = 2'd1,
		ST_SIZE = 2'd2,
		ST_ADDR = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_HEAD,
		S_LINK
	} ctrl_state_t;

endpackage

FILE: rtl/scfla_head_mem.sv
// ----------------------------------------------------------------------------
// scfla_head_mem: free-list head table
// One write port, one read port, registered read data. Each entry carries a
// valid bit cleared by reset; an entry never written reads as empty (zero).
// ----------------------------------------------------------------------------
module scfla_head_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int DW    = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0]    mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [DW-1:0]    rd_data_s1;
	logic             rd_valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_data_s1  <= mem[raddr];
			rd_valid_s1 <= valid_q[raddr];
		end
	end

	// an unwritten entry means an empty list
	assign rdata = rd_valid_s1 ? rd_data_s1 : '0;

endmodule

FILE: rtl/scfla_link_mem.sv
// ----------------------------------------------------------------------------
// scfla_link_mem: link word store
// Single-port-write, single-port-read RAM with registered read data; one
// link word per granule, contents undefined until written.
// ----------------------------------------------------------------------------
module scfla_link_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12,
	parameter int DW    = 13
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/size_class_free_list_allocator_core.sv
// Response: a beat accepted in S_IDLE is answered from S_HEAD, or from S_LINK
//   for an allocation served from a non-empty free list (head read, then link read).
// Flow: one request is in flight at a time; a new one is taken only in S_IDLE with a
//   free response slot, and the head/link memory read chain sets the pace.
// Reset (arst_n, async, active low): all free lists read empty, bump pointer
//   zero, response slot empty; no clearing pass, ready right after reset.
// ----------------------------------------------------------------------------
// size_class_free_list_allocator_core: segregated free-list allocator
// Allocates and frees blocks of 8-byte granules in SIZE_CLASSES size classes.
// Free-list heads live in a small head memory, the next-pointers in a link
// memory indexed by granule; fresh blocks come from a bump pointer.
// ----------------------------------------------------------------------------
module size_class_free_list_allocator_core #(
	parameter int ARENA_GRANULES = 4096,
	parameter int SIZE_CLASSES   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic                          command,
	input  logic [scfla_pkg::SIZE_W-1:0]  size_bytes,
	input  logic [scfla_pkg::ADDR_W-1:0]  block_address,
	// response channel
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [scfla_pkg::ADDR_W-1:0]  granted_address,
	output logic [scfla_pkg::STATUS_W-1:0] status
);
	import scfla_pkg::*;

	// link store index width
	localparam int AW  = (ARENA_GRANULES > 1) ? $clog2(ARENA_GRANULES) : 1;
	// head / link / bump width: holds 0..ARENA_GRANULES (lists coded as address + 1)
	localparam int HW  = $clog2(ARENA_GRANULES + 1);
	// class index width and class number (1..SIZE_CLASSES) width
	localparam int CIW = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
	localparam int KW  = $clog2(SIZE_CLASSES + 1);
	// wide enough for a 12-bit address plus class, and for any arena address
	localparam int SW  = ((HW > ADDR_W) ? HW : ADDR_W) + 1;
	localparam int MAX_BYTES = SIZE_CLASSES * GRANULE_BYTES;
	localparam int KQW = SIZE_W - GRANULE_SHIFT + 1;

	// ------------------------------------------------------------------
	// Request decode: class number k = ceil(size / 8), valid for 1..MAX_BYTES
	// ------------------------------------------------------------------
	logic           req_accept;
	logic           size_ok_in;
	logic [KQW-1:0] k_wide;
	logic [KW-1:0]  k_in;
	logic [KW-1:0]  ci_wide;
	logic [CIW-1:0] ci_in;

	assign size_ok_in = (size_bytes != '0) && (size_bytes <= SIZE_W'(MAX_BYTES));
	assign k_wide     = {1'b0, size_bytes[SIZE_W-1:GRANULE_SHIFT]}
	                  + KQW'(|size_bytes[GRANULE_SHIFT-1:0]);
	assign k_in       = k_wide[KW-1:0];
	assign ci_wide    = k_in - KW'(1);
	assign ci_in      = ci_wide[CIW-1:0];

	// ------------------------------------------------------------------
	// Request registers (stage 1) and controller state
	// ------------------------------------------------------------------
	ctrl_state_t state_q, state_d;

	logic              cmd_s1;
	logic              size_ok_s1;
	logic [KW-1:0]     k_s1;
	logic [CIW-1:0]    ci_s1;
	logic [ADDR_W-1:0] addr_s1;

	logic [HW-1:0]     blk_s2;
	logic              link_ok_s2;

	logic [HW-1:0]     bump_q;
	logic [HW-1:0]     bump_d;
	logic              bump_we;

	logic              rsp_valid_q;
	logic [ADDR_W-1:0] rsp_granted_q;
	status_t           rsp_status_q;

	// the response slot takes a new beat when empty or draining this cycle
	logic slot_free;
	assign slot_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall  = !((state_q == S_IDLE) && slot_free);
	assign req_accept = req_valid && !req_stall;

	// ------------------------------------------------------------------
	// Memories
	// ------------------------------------------------------------------
	logic           head_we;
	logic [CIW-1:0] head_waddr;
	logic [HW-1:0]  head_wdata;
	logic [HW-1:0]  head_rdata;

	logic           link_we;
	logic [AW-1:0]  link_waddr;
	logic [HW-1:0]  link_wdata;
	logic           link_re;
	logic [AW-1:0]  link_raddr;
	logic [HW-1:0]  link_rdata;

	// head read is issued with the accepted beat; data is back in S_HEAD
	scfla_head_mem #(
		.DEPTH (SIZE_CLASSES),
		.AW    (CIW),
		.DW    (HW)
	) u_head_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (head_we),
		.waddr  (head_waddr),
		.wdata  (head_wdata),
		.re     (req_accept),
		.raddr  (ci_in),
		.rdata  (head_rdata)
	);

	scfla_link_mem #(
		.DEPTH (ARENA_GRANULES),
		.AW    (AW),
		.DW    (HW)
	) u_link_mem (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (link_re),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	// ------------------------------------------------------------------
	// S_HEAD datapath: head just read, decide pop / bump / push
	// ------------------------------------------------------------------
	logic            head_empty;
	logic [HW-1:0]   blk;
	logic [HW:0]     hit_link;
	logic            hit_link_ok;
	logic [HW:0]     bump_end;
	logic            oom;
	logic [HW-1:0]   bump_link;
	logic [HW-1:0]   bump_next;
	logic [SW-1:0]   free_link;
	logic            free_ok;
	logic [SW-1:0]   bump_ext;
	logic [SW-1:0]   blk_ext;
	logic [SW-1:0]   free_head;

	assign head_empty  = (head_rdata == '0);
	assign blk         = head_rdata - HW'(1);
	assign hit_link    = {1'b0, blk} + (HW+1)'(k_s1);
	// a pushed block always has its link inside the arena; keep the guard anyway
	assign hit_link_ok = hit_link < (HW+1)'(ARENA_GRANULES);
	assign bump_end    = {1'b0, bump_q} + (HW+1)'(k_s1) + (HW+1)'(1);
	assign oom         = bump_end > (HW+1)'(ARENA_GRANULES);
	assign bump_link   = bump_q + HW'(k_s1);
	assign bump_next   = bump_end[HW-1:0];
	assign free_link   = SW'(addr_s1) + SW'(k_s1);
	assign free_ok     = free_link < SW'(ARENA_GRANULES);
	assign bump_ext    = SW'(bump_q);
	assign blk_ext     = SW'(blk_s2);
	assign free_head   = SW'(addr_s1) + SW'(1);

	// ------------------------------------------------------------------
	// Next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_accept) begin
					state_d = S_HEAD;
				end
			end
			S_HEAD: begin
				if (size_ok_s1 && (cmd_s1 == CMD_ALLOC) && !head_empty) begin
					state_d = S_LINK;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_LINK: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Controller outputs: memory writes, link read, bump update, response.
	// Writes land only in S_HEAD/S_LINK and the next head read waits for a
	// new accept, so no read ever overlaps a pending write to the same entry.
	// ------------------------------------------------------------------
	logic              rsp_load;
	logic [ADDR_W-1:0] rsp_granted_d;
	status_t           rsp_status_d;

	always_comb begin
		head_we       = 1'b0;
		head_waddr    = ci_s1;
		head_wdata    = '0;
		link_we       = 1'b0;
		link_waddr    = '0;
		link_wdata    = '0;
		link_re       = 1'b0;
		link_raddr    = hit_link[AW-1:0];
		bump_we       = 1'b0;
		bump_d        = bump_next;
		rsp_load      = 1'b0;
		rsp_granted_d = '0;
		rsp_status_d  = ST_OK;
		case (state_q)
			S_HEAD: begin
				if (!size_ok_s1) begin
					rsp_load     = 1'b1;
					rsp_status_d = ST_SIZE;
				end else if (cmd_s1 == CMD_ALLOC) begin
					if (!head_empty) begin
						// pop: fetch the next link, finish in S_LINK
						link_re = hit_link_ok;
					end else if (oom) begin
						rsp_load     = 1'b1;
						rsp_status_d = ST_OOM;
					end else begin
						// bump: terminate the new block's link word
						link_we       = 1'b1;
						link_waddr    = bump_link[AW-1:0];
						link_wdata    = '0;
						bump_we       = 1'b1;
						rsp_load      = 1'b1;
						rsp_granted_d = bump_ext[ADDR_W-1:0];
					end
				end else begin
					if (!free_ok) begin
						rsp_load     = 1'b1;
						rsp_status_d = ST_ADDR;
					end else begin
						// push: old head into the block's link word
						link_we    = 1'b1;
						link_waddr = free_link[AW-1:0];
						link_wdata = head_rdata;
						head_we    = 1'b1;
						head_wdata = free_head[HW-1:0];
						rsp_load   = 1'b1;
					end
				end
			end
			S_LINK: begin
				head_we       = 1'b1;
				head_wdata    = link_ok_s2 ? link_rdata : '0;
				rsp_load      = 1'b1;
				rsp_granted_d = blk_ext[ADDR_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			bump_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (bump_we) begin
				bump_q <= bump_d;
			end
			// load a result, or drop the held beat once taken
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// capture the request beat
	always_ff @(posedge clk) begin
		if (req_accept) begin
			cmd_s1     <= command;
			size_ok_s1 <= size_ok_in;
			k_s1       <= k_in;
			ci_s1      <= ci_in;
			addr_s1    <= block_address;
		end
	end

	// hold the popped block across the link read
	always_ff @(posedge clk) begin
		if (state_q == S_HEAD) begin
			blk_s2     <= blk;
			link_ok_s2 <= hit_link_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_granted_q <= rsp_granted_d;
			rsp_status_q  <= rsp_status_d;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign granted_address = rsp_granted_q;
	assign status          = rsp_status_q;

`ifndef SYNTHESIS
	// one request in flight: the response slot is empty while it is worked on
	a_slot_empty_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !rsp_valid_q)
		else $error("response slot occupied while a request is in flight");

	// a result is never loaded over a beat that is still held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |-> (!rsp_valid_q || !rsp_stall))
		else $error("response overwritten before it was taken");

	// the bump pointer never runs past the arena
	a_bump_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bump_q <= HW'(ARENA_GRANULES))
		else $error("bump pointer beyond arena");

	// a refused request never grants an address
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_load && (rsp_status_d != ST_OK)) |-> (rsp_granted_d == '0))
		else $error("nonzero address on a refused request");
`endif

endmodule
